// File: rtl/core/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types, constants and small tables of the line sensor steering unit.
// ----------------------------------------------------------------------------
package lss_pkg;

    // Sensor channels in use; the sensor field carries at most eight
    localparam int LSS_NUM_CH = 8;
    localparam int LSS_LANES  = (LSS_NUM_CH > 8) ? 8 : LSS_NUM_CH;

    // Configuration port
    localparam int LSS_ADDR_W = 4;
    localparam int LSS_DATA_W = 32;

    // Register reset values
    localparam logic [8:0]  ALPHA_RST     = 9'd179;
    localparam logic [15:0] GAIN_RST      = 16'd256;
    localparam logic [14:0] SLOW_THR_RST  = 15'd45;
    localparam logic [8:0]  SLOW_FAC_RST  = 9'd51;

    // Q1.8 unity for alpha and slow factor
    localparam logic [8:0]  Q8_ONE        = 9'd256;

    // Bound of the smoothed centroid (10.0 in Q.8)
    localparam int CENT_BOUND = 2560;

    // Per-lane result
    typedef struct packed {
        logic signed [4:0] weight;   // channel weight, zero when dark
        logic              lit;      // channel sees the line
        logic              start;    // lit with the channel below dark
    } lss_lane_t;

    // Configuration register set
    typedef struct packed {
        logic [8:0]  filter_alpha;
        logic [15:0] turn_gain;
        logic [14:0] slow_threshold;
        logic [8:0]  slow_factor;
    } lss_cfg_t;

    // Channel weights, +10 at channel 0 down to -10 at channel 7
    function automatic logic signed [4:0] chan_weight(input logic [2:0] chan);
        logic signed [4:0] w;
        case (chan)
            3'd0:    w = 5'sd10;
            3'd1:    w = 5'sd7;
            3'd2:    w = 5'sd4;
            3'd3:    w = 5'sd1;
            3'd4:    w = -5'sd1;
            3'd5:    w = -5'sd4;
            3'd6:    w = -5'sd7;
            3'd7:    w = -5'sd10;
            default: w = 5'sd0;
        endcase
        return w;
    endfunction

    // ceil(2^17 / count); numerators below 8192 divide exactly with it
    function automatic logic [17:0] recip(input logic [3:0] cnt);
        logic [17:0] r;
        case (cnt)
            4'd1:    r = 18'd131072;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            default: r = 18'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/line_sensor_steering_unit.sv
// ----------------------------------------------------------------------------
// line_sensor_steering_unit
// Line follower steering: lane-parallel weighted centroid, smoothing filter,
// done detection and forward drive commands.
// ----------------------------------------------------------------------------
// Input stream (s_*): one beat per sample. s_tuser is the command (0 trace
// sample, 1 stop). s_tdata carries line_sensors, speed, the target heading and
// the measured heading.
// Output stream (m_*): exactly one beat per input beat, in order. m_tuser holds
// done_res, drive_valid and clear_integrators; m_tdata holds velocity and
// turn_rate.
// Steps: a sample passes the lanes and merge on accept, then the reciprocal
// multiply for the divide by lit count, the filter multiply, and the
// turn-rate multiply which loads the output register. One sample is in
// flight at a time, so a new sample is not accepted until the last one has
// loaded the output register; s_tready is high while the sequencer is free.
// The output register decouples the sides: a new sample is accepted while a
// result waits; if m_tready stays low the next result holds in the last step
// and s_tready stays low.
// Reset: configuration returns to defaults, mode goes idle, the smoothed
// centroid clears, both streams are empty. Users write configuration over the
// APB port only while the unit is idle, unchecked here; pready is tied high.
// ----------------------------------------------------------------------------
module line_sensor_steering_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lss_pkg::LSS_ADDR_W-1:0]    paddr,
    input  logic [lss_pkg::LSS_DATA_W-1:0]    pwdata,
    output logic [lss_pkg::LSS_DATA_W-1:0]    prdata,
    output logic                              pready,
    // sample input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [55:0]                       s_tdata,  // line_sensors, speed, tgt_heading, cur_heading
    input  logic                              s_tuser,  // cmd
    // drive output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,  // velocity, turn_rate
    output logic [2:0]                        m_tuser   // done_res, drive_valid, clear_integrators
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FILT = 2'd2;
    localparam logic [1:0] ST_TURN = 2'd3;

    localparam int L = lss_pkg::LSS_LANES;

    lss_pkg::lss_cfg_t  cfg;
    lss_pkg::lss_lane_t lane_res [L];

    logic [L-1:0]      lit_vec;
    logic [L-1:0]      prev_vec;
    logic signed [5:0] m_sum;
    logic [3:0]        m_cnt;
    logic              m_done;

    logic [1:0]        state_reg, state_next;
    logic              cmd_reg;
    logic signed [5:0] sum_reg;
    logic [3:0]        cnt_reg;
    logic              done_reg;
    logic              slow_reg;
    logic signed [15:0] speed_reg;
    logic [30:0]       quot_prod_reg;
    logic signed [15:0] vel_reg;
    logic signed [12:0] smoothed_reg, smoothed_next;
    logic              mode_reg, mode_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg, m_tdata_next;
    logic [2:0]        m_tuser_reg, m_tuser_next;

    logic              accept;
    logic              out_free;

    // ------------------------------------------------------------------ config
    lss_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // ------------------------------------------------------------------ lanes
    assign lit_vec  = s_tdata[L-1:0];
    assign prev_vec = {lit_vec[L-2:0], 1'b0};

    for (genvar g = 0; g < L; g++)
    begin : g_lane
        lss_lane u_lane (
            .lit      (lit_vec[g]),
            .prev_lit (prev_vec[g]),
            .chan     (3'(g)),
            .res      (lane_res[g])
        );
    end

    lss_merge u_merge (
        .lane_res (lane_res),
        .sum      (m_sum),
        .cnt      (m_cnt),
        .done     (m_done)
    );

    // ------------------------------------------------------------------ accept
    logic signed [16:0] rot_err;
    logic [16:0]        rot_err_abs;
    logic               slow_in;

    assign accept      = s_tvalid & s_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign rot_err     = {s_tdata[39], s_tdata[39:24]} - {s_tdata[55], s_tdata[55:40]};
    assign rot_err_abs = rot_err[16] ? 17'(-rot_err) : rot_err;
    assign slow_in     = rot_err_abs < {2'b0, cfg.slow_threshold};

    // ------------------------------------------------------------------ divide step
    logic [4:0]         mag;
    logic [12:0]        numer;
    logic [30:0]        quot_prod_next;
    logic [8:0]         slow_fac;
    logic signed [25:0] spd_ext, fac_ext, vel_prod, vel_bias, vel_shift;
    logic signed [15:0] vel_next;

    // round(|S|*256 / C) via reciprocal multiply
    assign mag            = sum_reg[5] ? 5'(-sum_reg) : sum_reg[4:0];
    assign numer          = {mag, 8'b0} + {10'b0, cnt_reg[3:1]};
    assign quot_prod_next = {18'b0, numer} * {13'b0, lss_pkg::recip(cnt_reg)};

    // speed scaled near the target, truncated toward zero
    assign slow_fac  = (cfg.slow_factor > lss_pkg::Q8_ONE) ? lss_pkg::Q8_ONE : cfg.slow_factor;
    assign spd_ext   = {{10{speed_reg[15]}}, speed_reg};
    assign fac_ext   = {17'b0, slow_fac};
    assign vel_prod  = spd_ext * fac_ext;
    assign vel_bias  = vel_prod[25] ? vel_prod + 26'sd255 : vel_prod;
    assign vel_shift = vel_bias >>> 8;
    assign vel_next  = slow_reg ? vel_shift[15:0] : speed_reg;

    // ------------------------------------------------------------------ filter step
    logic [12:0]        quot;
    logic signed [13:0] raw;
    logic signed [14:0] diff;
    logic [8:0]         alpha;
    logic signed [24:0] diff_ext, alpha_ext, filt_prod;
    logic signed [25:0] filt_acc, filt_shift;

    // new = old + alpha*(raw - old), rounded to nearest by floor(+128)
    assign quot       = quot_prod_reg[29:17];
    assign raw        = sum_reg[5] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign diff       = {raw[13], raw} - {{2{smoothed_reg[12]}}, smoothed_reg};
    assign alpha      = (cfg.filter_alpha > lss_pkg::Q8_ONE) ? lss_pkg::Q8_ONE
                                                             : cfg.filter_alpha;
    assign diff_ext   = {{10{diff[14]}}, diff};
    assign alpha_ext  = {16'b0, alpha};
    assign filt_prod  = diff_ext * alpha_ext;
    assign filt_acc   = {{5{smoothed_reg[12]}}, smoothed_reg, 8'b0}
                      + {filt_prod[24], filt_prod} + 26'sd128;
    assign filt_shift = filt_acc >>> 8;

    // ------------------------------------------------------------------ turn step
    logic signed [29:0] sm_ext, gain_ext, turn_prod, turn_shift;
    logic [23:0]        turn_rate;

    // centroid*gain/256 stays well inside 24 bits, no clipping needed
    assign sm_ext     = {{17{smoothed_reg[12]}}, smoothed_reg};
    assign gain_ext   = {14'b0, cfg.turn_gain};
    assign turn_prod  = sm_ext * gain_ext;
    assign turn_shift = turn_prod >>> 8;
    assign turn_rate  = turn_shift[23:0];

    assign out_free = ~m_tvalid_reg | m_tready;

    // ------------------------------------------------------------------ sequencer
    always_comb
    begin
        state_next    = state_reg;
        smoothed_next = smoothed_reg;
        mode_next     = mode_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                if (!cmd_reg && cnt_reg != 4'd0)
                    smoothed_next = filt_shift[12:0];
                if (cmd_reg)
                    mode_next = 1'b0;
                else if (cnt_reg != 4'd0 && !done_reg)
                    mode_next = 1'b1;
                state_next = ST_TURN;
            end
            ST_TURN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (cmd_reg)
                        m_tuser_next = 3'b110;
                    else if (done_reg)
                        m_tuser_next = 3'b001;
                    else if (!mode_reg)
                        m_tuser_next = 3'b110;
                    else
                    begin
                        m_tuser_next = 3'b010;
                        m_tdata_next = {turn_rate, vel_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b0;
            smoothed_reg <= 13'sd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            smoothed_reg <= smoothed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser;
            sum_reg   <= m_sum;
            cnt_reg   <= m_cnt;
            done_reg  <= m_done;
            slow_reg  <= slow_in;
            speed_reg <= s_tdata[23:8];
        end
        if (state_reg == ST_DIV)
        begin
            quot_prod_reg <= quot_prod_next;
            vel_reg       <= vel_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------ checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DIV)
        else $error("accepted beat did not start the divide step");

    a_out_from_turn: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_TURN)
        else $error("result beat loaded outside the turn step");

    a_done_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("done and drive_valid both set");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[2]) |-> m_tdata == 40'd0)
        else $error("integrator clear with non-zero drive");

    a_cent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (smoothed_reg <= 13'(lss_pkg::CENT_BOUND))
        && (smoothed_reg >= -13'(lss_pkg::CENT_BOUND)))
        else $error("smoothed centroid out of range");

endmodule

// File: rtl/core/lss_lane.sv
// ----------------------------------------------------------------------------
// lss_lane
// One sensor channel: weight contribution and run start detection.
// ----------------------------------------------------------------------------
module lss_lane (
    input  logic                lit,
    input  logic                prev_lit,
    input  logic [2:0]          chan,
    output lss_pkg::lss_lane_t  res
);

    // Weight only counts for a lit channel; a run starts where the one below is dark
    always_comb
    begin
        res.weight = lit ? lss_pkg::chan_weight(chan) : 5'sd0;
        res.lit    = lit;
        res.start  = lit & ~prev_lit;
    end

endmodule

// File: rtl/core/lss_merge.sv
// ----------------------------------------------------------------------------
// lss_merge
// Combines the lanes: weight sum, lit count and single-run detection.
// ----------------------------------------------------------------------------
module lss_merge (
    input  lss_pkg::lss_lane_t  lane_res [lss_pkg::LSS_LANES],
    output logic signed [5:0]   sum,
    output logic [3:0]          cnt,
    output logic                done
);

    logic [3:0] runs;

    // Sum over lanes
    always_comb
    begin
        sum  = 6'sd0;
        cnt  = 4'd0;
        runs = 4'd0;
        for (int i = 0; i < lss_pkg::LSS_LANES; i++)
        begin
            sum  = sum + {lane_res[i].weight[4], lane_res[i].weight};
            cnt  = cnt + {3'b0, lane_res[i].lit};
            runs = runs + {3'b0, lane_res[i].start};
        end
        // one run of three or more adjacent lit channels
        done = (runs == 4'd1) && (cnt >= 4'd3);
    end

endmodule

// File: rtl/core/lss_cfg_regs.sv
// ----------------------------------------------------------------------------
// lss_cfg_regs
// APB register file holding the steering configuration.
// ----------------------------------------------------------------------------
module lss_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lss_pkg::LSS_ADDR_W-1:0]    paddr,
    input  logic [lss_pkg::LSS_DATA_W-1:0]    pwdata,
    output logic [lss_pkg::LSS_DATA_W-1:0]    prdata,
    output lss_pkg::lss_cfg_t                 cfg
);

    localparam logic [1:0] REG_FILTER_ALPHA   = 2'd0;
    localparam logic [1:0] REG_TURN_GAIN      = 2'd1;
    localparam logic [1:0] REG_SLOW_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_SLOW_FACTOR    = 2'd3;

    lss_pkg::lss_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_alpha   <= lss_pkg::ALPHA_RST;
            cfg_reg.turn_gain      <= lss_pkg::GAIN_RST;
            cfg_reg.slow_threshold <= lss_pkg::SLOW_THR_RST;
            cfg_reg.slow_factor    <= lss_pkg::SLOW_FAC_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FILTER_ALPHA:   cfg_reg.filter_alpha   <= pwdata[8:0];
                REG_TURN_GAIN:      cfg_reg.turn_gain      <= pwdata[15:0];
                REG_SLOW_THRESHOLD: cfg_reg.slow_threshold <= pwdata[14:0];
                REG_SLOW_FACTOR:    cfg_reg.slow_factor    <= pwdata[8:0];
                default:            ;
            endcase
        end
    end

    // Read-back
    always_comb
    begin
        case (reg_idx)
            REG_FILTER_ALPHA:   prdata = {23'b0, cfg_reg.filter_alpha};
            REG_TURN_GAIN:      prdata = {16'b0, cfg_reg.turn_gain};
            REG_SLOW_THRESHOLD: prdata = {17'b0, cfg_reg.slow_threshold};
            REG_SLOW_FACTOR:    prdata = {23'b0, cfg_reg.slow_factor};
            default:            prdata = '0;
        endcase
    end

endmodule

// File: tb/sv/lss_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lss_tb_pkg
// Command codes and register addresses shared by the stimulus and the checker
// of the line sensor steering unit.
// ----------------------------------------------------------------------------
package lss_tb_pkg;

    // Command carried on s_tuser
    typedef enum logic {
        CMD_TRACE = 1'b0,
        CMD_STOP  = 1'b1
    } lss_cmd_t;

    // Register byte addresses on the config port
    typedef enum logic [3:0] {
        REG_ALPHA    = 4'h0,
        REG_GAIN     = 4'h4,
        REG_SLOW_THR = 4'h8,
        REG_SLOW_FAC = 4'hC
    } lss_reg_addr_t;

endpackage

// File: tb/sv/lss_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lss_checker
// Watches the config port and both streams of the steering unit, predicts the
// drive beat for every accepted sample and compares it with the output beats.
// ----------------------------------------------------------------------------
module lss_checker
    import lss_tb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fails,
    output int          pending
);

    typedef struct packed {
        logic               done_res;
        logic               drive_valid;
        logic               clear_integrators;
        logic signed [15:0] velocity;
        logic signed [23:0] turn_rate;
    } drive_t;

    localparam logic [7:0] LANE_MASK = 8'((1 << lss_pkg::LSS_LANES) - 1);
    localparam int         CENT_HI   = 4095;
    localparam int         CENT_LO   = -4096;
    localparam longint     TURN_HI   = 64'sd8388607;
    localparam longint     TURN_LO   = -64'sd8388608;

    // Channel weights, left to right
    int lane_wt [8] = '{10, 7, 4, 1, -1, -4, -7, -10};

    // Shadow of the register set and of the steering state
    logic [8:0]  cfg_alpha;
    logic [15:0] cfg_gain;
    logic [14:0] cfg_slow_thr;
    logic [8:0]  cfg_slow_fac;
    logic        fwd_mode;
    int          cent_q8;

    drive_t drive_q [$];

    // Drive beat for one sample; advances mode and smoothed centroid
    function automatic drive_t steer_predict(input logic cmd, input logic [7:0] sens,
                                             input logic signed [15:0] spd,
                                             input logic signed [15:0] tgt,
                                             input logic signed [15:0] cur);
        drive_t     r;
        logic [7:0] lit;
        int         i, sum, cnt, pat, low, err;
        longint     a, f, mag, raw, acc, vel, turn;
        r = '0;
        if (cmd == CMD_STOP)
        begin
            fwd_mode = 1'b0;
            r.drive_valid = 1'b1;
            r.clear_integrators = 1'b1;
            return r;
        end
        lit = sens & LANE_MASK;
        sum = 0;
        cnt = 0;
        for (i = 0; i < 8; i++)
        begin
            if (lit[i])
            begin
                sum += lane_wt[i];
                cnt++;
            end
        end
        // centroid, rounded away from zero, then first-order smoothing
        if (cnt > 0)
        begin
            a   = (cfg_alpha > 9'd256) ? 256 : longint'(cfg_alpha);
            mag = longint'((sum < 0) ? -sum : sum) * 256;
            raw = (mag + cnt / 2) / cnt;
            if (sum < 0)
                raw = -raw;
            acc = (a * raw + (256 - a) * longint'(cent_q8) + 128) >>> 8;
            if (acc > CENT_HI)
                acc = CENT_HI;
            if (acc < CENT_LO)
                acc = CENT_LO;
            cent_q8 = int'(acc);
        end
        // a single run of at least three lit channels
        pat = int'(lit);
        low = pat & -pat;
        if (pat != 0 && ((pat + low) & pat) == 0 && $countones(lit) >= 3)
        begin
            r.done_res = 1'b1;
            return r;
        end
        if (lit != 8'h00)
            fwd_mode = 1'b1;
        r.drive_valid = 1'b1;
        if (!fwd_mode)
        begin
            r.clear_integrators = 1'b1;
            return r;
        end
        // forward drive
        err = int'(tgt) - int'(cur);
        if (err < 0)
            err = -err;
        vel = longint'(spd);
        if (err < int'(cfg_slow_thr))
        begin
            f   = (cfg_slow_fac > 9'd256) ? 256 : longint'(cfg_slow_fac);
            vel = (longint'(spd) * f) / 256;
        end
        turn = (longint'(cent_q8) * longint'(cfg_gain)) >>> 8;
        if (turn > TURN_HI)
            turn = TURN_HI;
        if (turn < TURN_LO)
            turn = TURN_LO;
        r.velocity  = 16'(vel);
        r.turn_rate = 24'(turn);
        return r;
    endfunction

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fails++;
        end
    endtask

    // Register writes, sample beats and drive beats, all at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        drive_t want, got;
        if (!rst_n)
        begin
            cfg_alpha    = lss_pkg::ALPHA_RST;
            cfg_gain     = lss_pkg::GAIN_RST;
            cfg_slow_thr = lss_pkg::SLOW_THR_RST;
            cfg_slow_fac = lss_pkg::SLOW_FAC_RST;
            fwd_mode     = 1'b0;
            cent_q8      = 0;
            fails        = 0;
            drive_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    REG_ALPHA:    cfg_alpha    = pwdata[8:0];
                    REG_GAIN:     cfg_gain     = pwdata[15:0];
                    REG_SLOW_THR: cfg_slow_thr = pwdata[14:0];
                    REG_SLOW_FAC: cfg_slow_fac = pwdata[8:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_q.push_back(steer_predict(s_tuser, s_tdata[7:0], s_tdata[23:8],
                                                s_tdata[39:24], s_tdata[55:40]));
            if (m_tvalid && m_tready)
            begin
                got.done_res          = m_tuser[0];
                got.drive_valid       = m_tuser[1];
                got.clear_integrators = m_tuser[2];
                got.velocity          = m_tdata[15:0];
                got.turn_rate         = m_tdata[39:16];
                if (drive_q.size() == 0)
                begin
                    $error("drive beat with no sample outstanding");
                    fails++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    check_field("done_res", want.done_res, got.done_res);
                    check_field("drive_valid", want.drive_valid, got.drive_valid);
                    check_field("clear_integrators", want.clear_integrators,
                                got.clear_integrators);
                    check_field("velocity", want.velocity, got.velocity);
                    check_field("turn_rate", want.turn_rate, got.turn_rate);
                end
            end
            pending <= drive_q.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the line sensor steering unit: directed samples, then random
// samples over several register settings with random idling on both streams,
// a long output hold-off and a full drain. Verdict from the checker's count.
// ----------------------------------------------------------------------------
module testbench;
    import lss_tb_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_GAP   = 8;
    localparam int PHASE_BEATS = 100;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready, s_tuser;
    logic [55:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    logic gaps_on, stall_on, long_hold;
    int   fails, pending;
    int   cyc = 0;
    int   hold_cnt;

    line_sensor_steering_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lss_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .fails    (fails),
        .pending  (pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle count and timeout
    always @(posedge clk)
        cyc <= cyc + 1;

    initial
    begin
        wait (cyc >= LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random stalls, plus one counted hold-off when asked
    initial
    begin
        hold_cnt = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold && hold_cnt < HOLD_CYCLES)
            begin
                m_tready <= 1'b0;
                hold_cnt++;
            end
            else
            begin
                if (!long_hold)
                    hold_cnt = 0;
                m_tready <= (stall_on && $urandom_range(99) < 24) ? 1'b0 : 1'b1;
            end
        end
    end

    // One sample beat, with random idle cycles ahead of it
    task automatic send_item(input lss_cmd_t cmd, input logic [7:0] sens,
                             input logic [15:0] spd, input logic [15:0] tgt,
                             input logic [15:0] cur);
        while (gaps_on && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {cur, tgt, spd, sens};
        do @(posedge clk); while (!s_tready);
    endtask

    // Stop offering and wait until every drive beat is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic reg_write(input lss_reg_addr_t addr, input int val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input int alpha, input int gain, input int thr, input int fac);
        wait_drained();
        reg_write(REG_ALPHA, alpha);
        reg_write(REG_GAIN, gain);
        reg_write(REG_SLOW_THR, thr);
        reg_write(REG_SLOW_FAC, fac);
    endtask

    // Sensor patterns: dark, single runs, single channels and anything
    function automatic logic [7:0] pick_sensors();
        int len, pos;
        case ($urandom_range(5))
            0: return 8'h00;
            1:
            begin
                len = $urandom_range(8, 3);
                pos = $urandom_range(8 - len);
                return 8'((1 << len) - 1) << pos;
            end
            2: return 8'h01 << $urandom_range(7);
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random();
        lss_cmd_t    cmd;
        logic [15:0] spd, tgt, cur;
        int          delta;
        cmd = ($urandom_range(99) < 8) ? CMD_STOP : CMD_TRACE;
        case ($urandom_range(7))
            0:       spd = 16'h8000;
            1:       spd = 16'h7FFF;
            default: spd = 16'($urandom);
        endcase
        tgt = 16'($urandom);
        // headings near each other most of the time, to reach the slow zone
        if ($urandom_range(2) != 0)
        begin
            delta = $urandom_range(400) - 200;
            cur   = tgt + 16'(delta);
        end
        else
            cur = 16'($urandom);
        send_item(cmd, pick_sensors(), spd, tgt, cur);
    endtask

    task automatic random_config();
        set_config($urandom_range(511), $urandom_range(65535),
                   ($urandom_range(1) != 0) ? $urandom_range(32767) : $urandom_range(400),
                   $urandom_range(511));
    endtask

    // Stimulus
    initial
    begin
        int ph, n;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_TRACE;
        s_tdata   <= '0;
        gaps_on   <= 1'b1;
        stall_on  <= 1'b1;
        long_hold <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed samples at reset settings
        send_item(CMD_TRACE, 8'h00, 16'sd1000, 16'sd0, 16'sd0);          // dark while idle
        send_item(CMD_STOP, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_item(CMD_TRACE, 8'h01, 16'h7FFF, 16'sd1000, 16'sd0);        // far left
        send_item(CMD_TRACE, 8'h80, 16'h8000, 16'sd1000, 16'sd0);        // far right
        send_item(CMD_TRACE, 8'h07, 16'sd500, 16'sd0, 16'sd0);           // run of three
        send_item(CMD_TRACE, 8'hE0, 16'sd500, 16'sd0, 16'sd0);
        send_item(CMD_TRACE, 8'hFF, 16'sd500, 16'sd0, 16'sd0);
        send_item(CMD_TRACE, 8'h00, 16'sd777, 16'sd0, 16'sd5000);        // dark, held
        send_item(CMD_TRACE, 8'h05, 16'sd1234, 16'sd100, 16'sd90);       // two runs
        send_item(CMD_TRACE, 8'h1B, 16'h8000, 16'sd100, 16'sd90);        // slow, negative speed
        send_item(CMD_TRACE, 8'h77, 16'h7FFF, 16'sd0, 16'sd44);          // just inside threshold
        send_item(CMD_TRACE, 8'h0C, 16'h7FFF, 16'sd0, 16'sd45);          // on the threshold
        send_item(CMD_TRACE, 8'h03, 16'h7FFF, 16'h8000, 16'h7FFF);       // widest error
        send_item(CMD_TRACE, 8'h18, 16'hFFFF, 16'h7FFF, 16'h8000);       // balanced
        send_item(CMD_TRACE, 8'h0F, 16'sd300, 16'sd0, 16'sd0);
        send_item(CMD_TRACE, 8'h3C, 16'sd300, 16'sd0, 16'sd0);
        send_item(CMD_TRACE, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555);
        send_item(CMD_TRACE, 8'h55, 16'hAAAA, 16'h5555, 16'hAAAA);
        send_item(CMD_TRACE, 8'h81, 16'sd1, 16'sd0, 16'sd0);
        send_item(CMD_TRACE, 8'hC0, 16'hFFFF, 16'sd0, 16'sd0);
        send_item(CMD_STOP, 8'h00, 16'sd0, 16'sd0, 16'sd0);
        send_item(CMD_TRACE, 8'h00, 16'sd100, 16'sd0, 16'sd0);          // dark after stop

        // random samples over a sequence of register settings
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       set_config(0, 65535, 32767, 0);
                1:       set_config(256, 0, 0, 256);
                2:       set_config(511, 1, 1, 511);
                3:       set_config(1, 32768, 300, 300);
                7:       set_config(lss_pkg::ALPHA_RST, lss_pkg::GAIN_RST,
                                    lss_pkg::SLOW_THR_RST, lss_pkg::SLOW_FAC_RST);
                default: random_config();
            endcase
            gaps_on  <= (ph != 4);
            stall_on <= (ph != 4);
            if (ph == 5)
            begin
                // hold the output long enough for the unit to back up
                long_hold <= 1'b1;
                for (n = 0; n < 40; n++)
                    send_random();
                long_hold <= 1'b0;
                wait_drained();
                for (n = 40; n < PHASE_BEATS; n++)
                    send_random();
            end
            else
            begin
                for (n = 0; n < PHASE_BEATS; n++)
                    send_random();
            end
        end

        wait_drained();
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
